// ===== hw/rtl/cppd_pkg.sv =====
// ----------------------------------------------------------------------------
// cppd_pkg
// Shared types and constants for the column-post pixel decoder.
// ----------------------------------------------------------------------------
package cppd_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);
    localparam int COLOR_W     = 24;
    localparam int COORD_W     = 12;
    localparam int BYTE_W      = 8;

    localparam logic [BYTE_W-1:0] END_MARK     = 8'hFF;
    localparam logic [7:0]        ALPHA_OPAQUE = 8'hFF;

    localparam logic FUNC_PAL  = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        PH_ROW  = 3'd0,
        PH_LEN  = 3'd1,
        PH_PAD1 = 3'd2,
        PH_PIX  = 3'd3,
        PH_PAD2 = 3'd4,
        PH_IDLE = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               rd;
    } res_t;

endpackage

// ===== hw/rtl/column_post_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// column_post_pixel_decoder
// Column-post picture decoder with palette lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item per byte. func=0
//   writes pal_color into palette entry pal_index; func=1 feeds data_byte
//   to the post parser, with col_start/column marking the first byte of a
//   column. Output channel (out_valid/out_ready) carries pixel, column-end
//   and abort items; argb is 0xFF-alpha palette colour for pixels, 0 else.
//   A taken item's result passes through the result stage (parse and palette
//   read) and then the output register.
//   Throughput: one item per cycle while in_ready is high; the parser state
//   updates in the accept cycle; palette is read once per pixel via its single port.
//   A result stage and the output register give two items of buffering, so
//   input is taken while one result waits on a stalled receiver; in_ready
//   drops only when both are full and out_ready is low.
//   Reset clears the parser, abort flag and width/height registers; the
//   palette holds no reset value and must be written before it is used.
//   Configuration (cfg_we/cfg_index/cfg_data) must be written while idle; unchecked.
// ----------------------------------------------------------------------------
module column_post_pixel_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [cppd_pkg::COORD_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic                         col_start,
    input  logic [cppd_pkg::COORD_W-1:0] column,
    input  logic [cppd_pkg::BYTE_W-1:0]  data_byte,
    input  logic [cppd_pkg::PAL_AW-1:0]  pal_index,
    input  logic [cppd_pkg::COLOR_W-1:0] pal_color,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   kind,
    output logic [cppd_pkg::COORD_W-1:0] pix_x,
    output logic [cppd_pkg::COORD_W-1:0] pix_y,
    output logic [31:0]                  argb
);
    import cppd_pkg::*;

    logic [COORD_W-1:0] width_reg, height_reg;
    logic               in_acc, data_acc, pal_acc;
    logic               out_free, s1_move;
    res_t               res;
    logic [COLOR_W-1:0] pal_rdata;

    logic               s1_valid_reg, s1_valid_next;
    kind_t              s1_kind_reg;
    logic [COORD_W-1:0] s1_x_reg, s1_y_reg;

    logic               out_valid_reg, out_valid_next;
    kind_t              out_kind_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic [31:0]        out_argb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_acc   = in_valid && in_ready;
    assign data_acc = in_acc && (func == FUNC_DATA);
    assign pal_acc  = in_acc && (func == FUNC_PAL);

    cppd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (data_acc),
        .col_start    (col_start),
        .column       (column),
        .data_byte    (data_byte),
        .image_width  (width_reg),
        .image_height (height_reg),
        .res          (res)
    );

    cppd_palette u_palette (
        .clk   (clk),
        .we    (pal_acc),
        .waddr (pal_index),
        .wdata (pal_color),
        .re    (data_acc && res.rd),
        .raddr (data_byte),
        .rdata (pal_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg && !s1_move;
        if (data_acc && res.valid)
        begin
            s1_valid_next = 1'b1;
        end
        out_valid_next = s1_move || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_acc && res.valid)
        begin
            s1_kind_reg <= res.kind;
            s1_x_reg    <= res.x;
            s1_y_reg    <= res.y;
        end
        if (s1_move)
        begin
            out_kind_reg <= s1_kind_reg;
            out_x_reg    <= s1_x_reg;
            out_y_reg    <= s1_y_reg;
            out_argb_reg <= (s1_kind_reg == KIND_PIXEL) ? {ALPHA_OPAQUE, pal_rdata} : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign pix_x     = out_x_reg;
    assign pix_y     = out_y_reg;
    assign argb      = out_argb_reg;

    a_pixel_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_PIXEL |-> out_argb_reg[31:24] == ALPHA_OPAQUE)
        else $error("pixel item without opaque alpha");

    a_event_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg != KIND_PIXEL |-> out_argb_reg == '0)
        else $error("event item with nonzero color");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken with both result stages full");

    a_result_staged: assert property (@(posedge clk) disable iff (!rst_n)
        data_acc && res.valid |=> s1_valid_reg)
        else $error("result of accepted item lost");

    a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("result stage moved without output register load");

endmodule

// ===== hw/rtl/cppd_palette.sv =====
// ----------------------------------------------------------------------------
// cppd_palette
// 256 x 24 palette memory, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cppd_palette (
    input  logic                         clk,
    input  logic                         we,
    input  logic [cppd_pkg::PAL_AW-1:0]  waddr,
    input  logic [cppd_pkg::COLOR_W-1:0] wdata,
    input  logic                         re,
    input  logic [cppd_pkg::PAL_AW-1:0]  raddr,
    output logic [cppd_pkg::COLOR_W-1:0] rdata
);
    import cppd_pkg::*;

    logic [COLOR_W-1:0] mem [PAL_ENTRIES];
    logic [COLOR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/cppd_parser.sv =====
// ----------------------------------------------------------------------------
// cppd_parser
// Post stream parser: tracks phase, post geometry and abort state, and
// decides the result of each accepted data item.
// ----------------------------------------------------------------------------
module cppd_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         col_start,
    input  logic [cppd_pkg::COORD_W-1:0] column,
    input  logic [cppd_pkg::BYTE_W-1:0]  data_byte,
    input  logic [cppd_pkg::COORD_W-1:0] image_width,
    input  logic [cppd_pkg::COORD_W-1:0] image_height,
    output cppd_pkg::res_t               res
);
    import cppd_pkg::*;

    phase_t             phase_reg, phase_next, phase_eff;
    logic [BYTE_W-1:0]  start_row_reg, start_row_next, start_row_eff;
    logic [BYTE_W-1:0]  length_reg, length_next, length_eff;
    logic [BYTE_W-1:0]  offset_reg, offset_next, offset_eff, offset_inc;
    logic [COORD_W-1:0] column_reg, column_next, column_eff;
    logic               aborted_reg, aborted_next, aborted_eff;
    logic [BYTE_W:0]    row_sum;
    logic               row_over;

    // column start handling ahead of the phase decode
    always_comb
    begin
        aborted_eff   = aborted_reg && !(col_start && column == '0);
        phase_eff     = phase_reg;
        start_row_eff = start_row_reg;
        length_eff    = length_reg;
        offset_eff    = offset_reg;
        column_eff    = column_reg;
        if (col_start && !aborted_eff)
        begin
            column_eff    = column;
            offset_eff    = '0;
            start_row_eff = '0;
            length_eff    = '0;
            phase_eff     = (column < image_width) ? PH_ROW : PH_IDLE;
        end
    end

    assign row_sum    = {1'b0, start_row_eff} + {1'b0, offset_eff};
    assign row_over   = {{(COORD_W-BYTE_W-1){1'b0}}, row_sum} >= image_height;
    assign offset_inc = offset_eff + 8'd1;

    // next state
    always_comb
    begin
        phase_next     = phase_eff;
        start_row_next = start_row_eff;
        length_next    = length_eff;
        offset_next    = offset_eff;
        column_next    = column_eff;
        aborted_next   = aborted_eff;
        if (!aborted_eff)
        begin
            unique case (phase_eff)
                PH_ROW:
                begin
                    if (data_byte == END_MARK)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        start_row_next = data_byte;
                        phase_next     = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    length_next = data_byte;
                    phase_next  = PH_PAD1;
                end
                PH_PAD1:
                begin
                    offset_next = '0;
                    phase_next  = (length_eff == '0) ? PH_PAD2 : PH_PIX;
                end
                PH_PIX:
                begin
                    if (row_over)
                    begin
                        aborted_next = 1'b1;
                        phase_next   = PH_IDLE;
                    end
                    else
                    begin
                        offset_next = offset_inc;
                        if (offset_inc >= length_eff)
                        begin
                            phase_next = PH_PAD2;
                        end
                    end
                end
                PH_PAD2: phase_next = PH_ROW;
                PH_IDLE: phase_next = PH_IDLE;
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // result decode
    always_comb
    begin
        res       = '0;
        res.kind  = KIND_PIXEL;
        res.x     = column_eff;
        if (!aborted_eff)
        begin
            unique case (phase_eff)
                PH_ROW:
                begin
                    if (data_byte == END_MARK)
                    begin
                        res.valid = 1'b1;
                        res.kind  = KIND_END;
                    end
                end
                PH_PIX:
                begin
                    res.valid = 1'b1;
                    res.y     = {{(COORD_W-BYTE_W-1){1'b0}}, row_sum};
                    if (row_over)
                    begin
                        res.kind = KIND_ABORT;
                    end
                    else
                    begin
                        res.rd = 1'b1;
                    end
                end
                PH_LEN, PH_PAD1, PH_PAD2, PH_IDLE: res.valid = 1'b0;
                default: res.valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ROW;
            start_row_reg <= '0;
            length_reg    <= '0;
            offset_reg    <= '0;
            column_reg    <= '0;
            aborted_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            start_row_reg <= start_row_next;
            length_reg    <= length_next;
            offset_reg    <= offset_next;
            column_reg    <= column_next;
            aborted_reg   <= aborted_next;
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the column-post pixel decoder. A directed table
// covers palette extremes, post framing, zero-length posts, row overflow
// abort and recovery, and out-of-range columns. Random post streams follow
// over several picture geometries, with idle gaps and stalls on both sides.
// A decoder kept in step with the input predicts each pixel, column end and
// abort, and every output item is compared in order.
// ----------------------------------------------------------------------------
module tb;
    import cppd_pkg::*;

    localparam int LIMIT_NS    = 5_000_000;
    localparam int HOLD_CYCLES = 150;
    localparam int IDLE_PCT    = 31;

    typedef struct packed {
        logic               fn;
        logic               st;
        logic [COORD_W-1:0] col;
        logic [BYTE_W-1:0]  dat;
        logic [PAL_AW-1:0]  pidx;
        logic [COLOR_W-1:0] pcolor;
    } item_t;

    typedef struct packed {
        kind_t              k;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [31:0]        c;
    } pixel_res_t;

    typedef struct packed {
        item_t      it;
        logic       typed;
        pixel_res_t res;
    } dir_row_t;

    typedef struct packed {
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        int                 items;
    } geom_t;

    localparam pixel_res_t NO_RES = '{KIND_PIXEL, 12'd0, 12'd0, 32'd0};

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = CFG_WIDTH;
    logic [COORD_W-1:0] cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic               func      = FUNC_PAL;
    logic               col_start = 1'b0;
    logic [COORD_W-1:0] column    = '0;
    logic [BYTE_W-1:0]  data_byte = '0;
    logic [PAL_AW-1:0]  pal_index = '0;
    logic [COLOR_W-1:0] pal_color = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         kind;
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;
    logic [31:0]        argb;

    // decoder state kept alongside the block
    logic [COLOR_W-1:0] pal_mem [PAL_ENTRIES];
    bit                 pal_written [PAL_ENTRIES];
    logic [PAL_AW-1:0]  pal_known [$];
    phase_t             ph       = PH_ROW;
    logic [BYTE_W-1:0]  row_base = '0;
    logic [BYTE_W-1:0]  post_len = '0;
    logic [BYTE_W-1:0]  pix_off  = '0;
    logic [COORD_W-1:0] cur_col  = '0;
    bit                 halted   = 1'b0;
    logic [COORD_W-1:0] img_w    = '0;
    logic [COORD_W-1:0] img_h    = '0;

    pixel_res_t pixels_due [$];
    int         n_mismatch = 0;
    int         hold_req   = 0;
    int         hold_ack   = 0;
    int         hold_left  = 0;
    bit         calm       = 1'b0;

    // run with width 16, height 64
    dir_row_t dir_tab [25] = '{
        '{'{FUNC_PAL,  1'b0, 12'd0,    8'h00,    8'h00, 24'h000000}, 1'b0, NO_RES},
        '{'{FUNC_PAL,  1'b0, 12'd0,    8'h00,    8'hFF, 24'hFFFFFF}, 1'b0, NO_RES},
        '{'{FUNC_PAL,  1'b0, 12'd0,    8'h00,    8'h5A, 24'hA5C35A}, 1'b0, NO_RES},
        '{'{FUNC_DATA, 1'b0, 12'd0,    END_MARK, 8'h00, 24'h000000}, 1'b1,
          '{KIND_END, 12'd0, 12'd0, 32'h0}},
        '{'{FUNC_DATA, 1'b1, 12'd3,    8'd10,    8'h00, 24'h000000}, 1'b0, NO_RES},
        '{'{FUNC_DATA, 1'b0, 12'd0,    8'd2,     8'h00, 24'h000000}, 1'b0, NO_RES},
        '{'{FUNC_DATA, 1'b0, 12'd0,    8'h77,    8'h00, 24'h000000}, 1'b0, NO_RES},
        '{'{FUNC_DATA, 1'b0, 12'd0,    8'h00,    8'h00, 24'h000000}, 1'b1,
          '{KIND_PIXEL, 12'd3, 12'd10, 32'hFF000000}},
        '{'{FUNC_DATA, 1'b0, 12'd0,    8'hFF,    8'h00, 24'h000000}, 1'b1,
          '{KIND_PIXEL, 12'd3, 12'd11, 32'hFFFFFFFF}},
        '{'{FUNC_DATA, 1'b0, 12'd0,    8'hFF,    8'h00, 24'h000000}, 1'b0, NO_RES},
        '{'{FUNC_DATA, 1'b0, 12'd0,    8'd0,     8'h00, 24'h000000}, 1'b0, NO_RES},
        '{'{FUNC_DATA, 1'b0, 12'd0,    8'd0,     8'h00, 24'h000000}, 1'b0, NO_RES},
        '{'{FUNC_DATA, 1'b0, 12'd0,    8'h33,    8'h00, 24'h000000}, 1'b0, NO_RES},
        '{'{FUNC_DATA, 1'b0, 12'd0,    8'h44,    8'h00, 24'h000000}, 1'b0, NO_RES},
        '{'{FUNC_DATA, 1'b0, 12'd0,    8'd63,    8'h00, 24'h000000}, 1'b0, NO_RES},
        '{'{FUNC_DATA, 1'b0, 12'd0,    8'd3,     8'h00, 24'h000000}, 1'b0, NO_RES},
        '{'{FUNC_DATA, 1'b0, 12'd0,    8'h00,    8'h00, 24'h000000}, 1'b0, NO_RES},
        '{'{FUNC_DATA, 1'b0, 12'd0,    8'h5A,    8'h00, 24'h000000}, 1'b1,
          '{KIND_PIXEL, 12'd3, 12'd63, 32'hFFA5C35A}},
        '{'{FUNC_DATA, 1'b0, 12'd0,    8'h00,    8'h00, 24'h000000}, 1'b1,
          '{KIND_ABORT, 12'd3, 12'd64, 32'h0}},
        '{'{FUNC_DATA, 1'b1, 12'd5,    8'd0,     8'h00, 24'h000000}, 1'b0, NO_RES},
        '{'{FUNC_PAL,  1'b0, 12'd0,    8'h00,    8'h01, 24'h123456}, 1'b0, NO_RES},
        '{'{FUNC_DATA, 1'b1, 12'd0,    END_MARK, 8'h00, 24'h000000}, 1'b1,
          '{KIND_END, 12'd0, 12'd0, 32'h0}},
        '{'{FUNC_DATA, 1'b1, 12'hFFF,  END_MARK, 8'h00, 24'h000000}, 1'b0, NO_RES},
        '{'{FUNC_DATA, 1'b1, 12'd15,   END_MARK, 8'h00, 24'h000000}, 1'b1,
          '{KIND_END, 12'd15, 12'd0, 32'h0}},
        '{'{FUNC_DATA, 1'b0, 12'd0,    END_MARK, 8'h00, 24'h000000}, 1'b0, NO_RES}
    };

    geom_t geoms [6] = '{
        '{12'd4095, 12'd4095, 420},
        '{12'd0,    12'd4095, 80},
        '{12'd24,   12'd0,    160},
        '{12'd40,   12'd120,  480},
        '{12'd4095, 12'd200,  400},
        '{12'd1,    12'd255,  180}
    };

    column_post_pixel_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .col_start (col_start),
        .column    (column),
        .data_byte (data_byte),
        .pal_index (pal_index),
        .pal_color (pal_color),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .argb      (argb)
    );

    always #5 clk = ~clk;

    function automatic bit decode_item(input item_t it, output pixel_res_t r);
        logic [COORD_W-1:0] y;
        r = NO_RES;
        y = '0;
        if (it.fn == FUNC_PAL)
        begin
            if (!pal_written[it.pidx])
                pal_known.push_back(it.pidx);
            pal_written[it.pidx] = 1'b1;
            pal_mem[it.pidx] = it.pcolor;
            return 1'b0;
        end
        if (it.st)
        begin
            if (halted && it.col == '0)
                halted = 1'b0;
            if (!halted)
            begin
                cur_col  = it.col;
                pix_off  = '0;
                row_base = '0;
                post_len = '0;
                ph = (it.col < img_w) ? PH_ROW : PH_IDLE;
            end
        end
        if (halted)
            return 1'b0;
        case (ph)
            PH_ROW:
            begin
                if (it.dat == END_MARK)
                begin
                    ph = PH_IDLE;
                    r = '{KIND_END, cur_col, 12'd0, 32'd0};
                    return 1'b1;
                end
                row_base = it.dat;
                ph = PH_LEN;
            end
            PH_LEN:
            begin
                post_len = it.dat;
                ph = PH_PAD1;
            end
            PH_PAD1:
            begin
                pix_off = '0;
                ph = (post_len == 0) ? PH_PAD2 : PH_PIX;
            end
            PH_PIX:
            begin
                y = {4'd0, row_base} + {4'd0, pix_off};
                if (y >= img_h)
                begin
                    halted = 1'b1;
                    ph = PH_IDLE;
                    r = '{KIND_ABORT, cur_col, y, 32'd0};
                    return 1'b1;
                end
                pix_off = pix_off + 8'd1;
                if (pix_off >= post_len)
                    ph = PH_PAD2;
                r = '{KIND_PIXEL, cur_col, y, {ALPHA_OPAQUE, pal_mem[it.dat]}};
                return 1'b1;
            end
            PH_PAD2:
                ph = PH_ROW;
            default:
                ;
        endcase
        return 1'b0;
    endfunction

    // start row, biased toward the overflow boundary, or column end
    function automatic logic [BYTE_W-1:0] row_or_end();
        int roll;
        int row;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return END_MARK;
        if (roll < 45)
        begin
            row = int'(img_h) - int'($urandom_range(0, 6));
            if (row < 0)
                row = 0;
            if (row > 254)
                row = 254;
            return 8'(row);
        end
        return 8'($urandom_range(0, 254));
    endfunction

    // mostly well-formed posts with random content, some noise
    function automatic item_t next_stream_item();
        item_t it;
        int    roll;
        it.fn     = FUNC_DATA;
        it.st     = 1'b0;
        it.col    = 12'($urandom);
        it.dat    = 8'($urandom);
        it.pidx   = 8'($urandom);
        it.pcolor = 24'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 8)
            it.fn = FUNC_PAL;
        else if (roll < 14)
            it.st = ($urandom_range(0, 3) == 0);
        else if (halted)
        begin
            it.st = ($urandom_range(0, 2) != 0);
            if (it.st)
            begin
                it.col = '0;
                it.dat = row_or_end();
            end
        end
        else
        begin
            case (ph)
                PH_IDLE:
                begin
                    it.st = 1'b1;
                    roll = $urandom_range(0, 99);
                    if (img_w != 0 && roll < 70)
                        it.col = 12'($urandom_range(0, int'(img_w) - 1));
                    else if (roll < 80)
                        it.col = '0;
                    it.dat = row_or_end();
                end
                PH_ROW:
                    it.dat = row_or_end();
                PH_LEN:
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70)
                        it.dat = 8'($urandom_range(0, 6));
                    else if (roll < 95)
                        it.dat = 8'($urandom_range(7, 40));
                    else
                        it.dat = 8'($urandom_range(41, 255));
                end
                default:
                    ;
            endcase
        end
        // any palette lookup must hit a written entry
        if (it.fn == FUNC_DATA && !it.st && !halted && ph == PH_PIX)
            it.dat = pal_known[$urandom_range(0, pal_known.size() - 1)];
        return it;
    endfunction

    task automatic offer_item(input item_t it, input bit typed, input pixel_res_t want);
        pixel_res_t r;
        bit         has;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        has = decode_item(it, r);
        if (typed)
            pixels_due.push_back(want);
        else if (has)
            pixels_due.push_back(r);
        {func, col_start, column, data_byte, pal_index, pal_color} <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        img_w = w;
        img_h = h;
    endtask

    // receiver: random stalls, plus a long hold on request
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        pixel_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pixels_due.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("%0t: unexpected item kind=%0d x=%0d y=%0d argb=%h",
                             $realtime, kind, pix_x, pix_y, argb);
            end
            else
            begin
                want = pixels_due.pop_front();
                if (kind !== want.k || pix_x !== want.x || pix_y !== want.y
                    || argb !== want.c)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                    begin
                        $write("%0t: exp kind=%0d x=%0d y=%0d argb=%h, ",
                               $realtime, want.k, want.x, want.y, want.c);
                        $display("got kind=%0d x=%0d y=%0d argb=%h",
                                 kind, pix_x, pix_y, argb);
                    end
                end
            end
        end
    end

    initial
    begin
        int n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_geometry(12'd16, 12'd64);
        foreach (dir_tab[i])
            offer_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
        in_valid <= 1'b0;
        drain();
        foreach (geoms[g])
        begin
            set_geometry(geoms[g].w, geoms[g].h);
            for (n = 0; n < geoms[g].items; n++)
            begin
                if (g == 0 && n == 100)
                begin
                    calm     <= 1'b1;
                    hold_req <= hold_req + 1;
                end
                if (g == 0 && n == 260)
                    calm <= 1'b0;
                if (g == 3 && n == 200)
                begin
                    in_valid <= 1'b0;
                    drain();
                end
                offer_item(next_stream_item(), 1'b0, NO_RES);
            end
            in_valid <= 1'b0;
            drain();
        end
        repeat (10) @(posedge clk);
        if (n_mismatch == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
